FILE: rtl/core/bsts_pkg.sv
// Shared constants, register indexes, request codes and divider types for the slot timing block.
package bsts_pkg;

    // Time arithmetic wraps at this many bits
    localparam int TIME_WIDTH = 48;
    localparam int CNT_W      = $clog2(TIME_WIDTH + 1);

    // Divisor and remainder width of the serial divider
    localparam int DVS_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GUARD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RX_WINDOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TX_JITTER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_PPM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_CLASS = 3'd6;

    // Request codes
    localparam logic [1:0] REQ_ANCHOR = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_RESYNC = 2'd2;

    // Register reset values
    localparam logic [15:0] PERIOD_RESET     = 16'd1000;
    localparam logic [9:0]  GUARD_RESET      = 10'd10;
    localparam logic [9:0]  RX_WINDOW_RESET  = 10'd20;
    localparam logic [9:0]  TX_JITTER_RESET  = 10'd4;
    localparam logic [6:0]  GAIN_RESET       = 7'd4;
    localparam logic [9:0]  DRIFT_PPM_RESET  = 10'd40;
    localparam logic [7:0]  CLASS_RESET      = 8'd255;

    // Fallbacks for zero-valued registers
    localparam logic [15:0] PERIOD_DEFAULT = 16'd1000;
    localparam logic [6:0]  GAIN_DEFAULT   = 7'd1;

    // Milliseconds per second, also the ppm scaling step
    localparam logic [DVS_W-1:0] MS_PER_S = 16'd1000;

    // Width of the drift multiplier's ppm operand
    localparam int PPM_W     = 10;
    localparam int MUL_CNT_W = $clog2(PPM_W + 1);

    typedef struct packed {
        logic                  start;
        logic [TIME_WIDTH-1:0] dividend;
        logic [DVS_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [TIME_WIDTH-1:0] quot;
        logic [DVS_W-1:0]      rem;
    } div_rsp_t;

endpackage

FILE: rtl/core/beat_slot_timing_sync.sv
// Top level of the slot timing block: configuration, request sequencer and result register.
//
// Usage: configuration registers are written through cfg_wr_en / cfg_index / cfg_data,
// one register per cycle, while the block is idle. Requests arrive on the in_valid /
// in_ready channel (req_type, time_ms, peer_class); each request yields exactly one
// result on the out_valid / out_ready channel.
// An anchor request sets the epoch, the last-resync time and the own clock class. A query
// only reports. A resync from a peer of equal or better class corrects the epoch.
// Requests share the single bit-serial divider. A request uses three to six divider
// passes (phase, guard modulo, drift scaling, resync offset and gain): guard modulo runs
// only when the guard exceeds the period, resync offset only for a resync that is taken,
// and gain only when that offset lies inside the guard. A shift-add multiplier scales
// the drift.
// One request is in work at a time; in_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next request is taken while the previous
// result waits; when the receiver stalls, the finished result is held until out_ready.
// Reset clears the configuration to its defaults, the epoch and last-resync time to zero
// and the own class to 255; no result is pending after reset.
module beat_slot_timing_sync (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bsts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsts_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        req_type,
    input  logic [bsts_pkg::TIME_WIDTH-1:0]   time_ms,
    input  logic [7:0]                        peer_class,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              slot_open,
    output logic [15:0]                       until_next_slot,
    output logic [16:0]                       until_tx,
    output logic [31:0]                       drift_us,
    output logic                              resync_taken,
    output logic signed [16:0]                applied_offset,
    output logic [7:0]                        own_class
);

    localparam int TW  = bsts_pkg::TIME_WIDTH;
    localparam int MCW = bsts_pkg::MUL_CNT_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_P0_WAIT = 4'd2;
    localparam logic [3:0] S_CORR    = 4'd3;
    localparam logic [3:0] S_GD_WAIT = 4'd4;
    localparam logic [3:0] S_APPLY   = 4'd5;
    localparam logic [3:0] S_PHASE   = 4'd6;
    localparam logic [3:0] S_PH_WAIT = 4'd7;
    localparam logic [3:0] S_GMOD    = 4'd8;
    localparam logic [3:0] S_GM_WAIT = 4'd9;
    localparam logic [3:0] S_SINCE   = 4'd10;
    localparam logic [3:0] S_SN_WAIT = 4'd11;
    localparam logic [3:0] S_MUL     = 4'd12;
    localparam logic [3:0] S_RDIV    = 4'd13;
    localparam logic [3:0] S_RD_WAIT = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    // Configuration registers
    logic [15:0] period_reg;
    logic [9:0]  guard_reg;
    logic [9:0]  rx_reg;
    logic [9:0]  jitter_reg;
    logic [6:0]  gain_reg;
    logic [9:0]  ppm_reg;
    logic [7:0]  init_class_reg;

    // Schedule state
    logic [TW-1:0] epoch_reg;
    logic [TW-1:0] last_reg;
    logic [7:0]    class_reg;

    // Sequencer
    logic [3:0]     state_reg;
    logic [3:0]     state_next;
    logic [MCW-1:0] mul_cnt_reg;

    // Captured transaction
    logic [1:0]    req_reg;
    logic [TW-1:0] t_reg;
    logic [7:0]    peer_reg;

    // Working registers
    logic signed [17:0] off_reg;
    logic signed [17:0] applied_reg;
    logic               taken_reg;
    logic [15:0]        p_reg;
    logic [9:0]         g_reg;
    logic [31:0]        mq_reg;
    logic [19:0]        mr_reg;
    logic [9:0]         mp_reg;
    logic [31:0]        accq_reg;
    logic [19:0]        accr_reg;
    logic [31:0]        drift_reg;

    // Result register
    logic               out_valid_reg;
    logic               open_reg;
    logic [15:0]        until_next_reg;
    logic [16:0]        until_tx_reg;
    logic [31:0]        drift_out_reg;
    logic               taken_out_reg;
    logic signed [16:0] applied_out_reg;
    logic [7:0]         class_out_reg;

    bsts_pkg::div_req_t div_req;
    bsts_pkg::div_rsp_t div_rsp;

    logic [15:0]        per_eff;
    logic [6:0]         gain_eff;
    logic [TW-1:0]      since_epoch;
    logic [TW-1:0]      since_last;
    logic               resync_ok;
    logic               guard_gt_per;
    logic signed [17:0] off_fold;
    logic signed [17:0] off_bias;
    logic signed [17:0] guard_s;
    logic               outside;
    logic [17:0]        mag;
    logic [17:0]        qsmall;
    logic [17:0]        applied_div;
    logic               can_load;
    logic [10:0]        rx_plus;
    logic               guard_le;
    logic [15:0]        per_m_guard;
    logic               open_c;
    logic [15:0]        until_next_c;
    logic [15:0]        target;
    logic [16:0]        until_tx_c;

    bsts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Effective period and gain, time differences
    always_comb
    begin
        per_eff      = (period_reg == '0) ? bsts_pkg::PERIOD_DEFAULT : period_reg;
        gain_eff     = (gain_reg == '0) ? bsts_pkg::GAIN_DEFAULT : gain_reg;
        since_epoch  = t_reg - epoch_reg;
        since_last   = t_reg - last_reg;
        resync_ok    = (req_reg == bsts_pkg::REQ_RESYNC) && (peer_reg <= class_reg);
        guard_gt_per = {6'b0, guard_reg} > per_eff;
    end

    // Fold the phase into a signed offset and remove the jitter bias
    always_comb
    begin
        if (div_rsp.rem > {1'b0, per_eff[15:1]})
            off_fold = $signed({2'b0, div_rsp.rem}) - $signed({2'b0, per_eff});
        else
            off_fold = $signed({2'b0, div_rsp.rem});
        off_bias = off_fold - $signed({9'b0, jitter_reg[9:1]});
    end

    // Guard test and signed gain division around the unsigned divider
    always_comb
    begin
        guard_s     = $signed({8'b0, guard_reg});
        outside     = (off_reg > guard_s) || (off_reg < -guard_s);
        mag         = off_reg[17] ? 18'(-off_reg) : 18'(off_reg);
        qsmall      = div_rsp.quot[17:0];
        applied_div = off_reg[17] ? (18'd0 - qsmall) : qsmall;
    end

    // Window timing from the final phase
    always_comb
    begin
        rx_plus      = {1'b0, rx_reg} + {1'b0, guard_reg};
        guard_le     = {6'b0, guard_reg} <= per_eff;
        per_m_guard  = per_eff - {6'b0, guard_reg};
        open_c       = (p_reg < {5'b0, rx_plus}) || (guard_le && (p_reg >= per_m_guard));
        until_next_c = open_c ? 16'd0 : (per_m_guard - p_reg);
        target       = per_eff - {6'b0, g_reg};
        if (p_reg <= target)
            until_tx_c = {1'b0, target - p_reg};
        else
            until_tx_c = {1'b0, per_eff} - {1'b0, p_reg} + {1'b0, target};
    end

    assign can_load = !out_valid_reg || out_ready;

    // Drive the divider from the sequencer
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = since_epoch;
        div_req.divisor  = per_eff;
        unique case (state_reg)
            S_DECIDE:
            begin
                div_req.start = resync_ok;
            end
            S_CORR:
            begin
                div_req.start    = !outside;
                div_req.dividend = TW'(mag);
                div_req.divisor  = {9'b0, gain_eff};
            end
            S_PHASE:
            begin
                div_req.start = 1'b1;
            end
            S_GMOD:
            begin
                div_req.start    = guard_gt_per;
                div_req.dividend = TW'(guard_reg);
            end
            S_SINCE:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = since_last;
                div_req.divisor  = bsts_pkg::MS_PER_S;
            end
            S_RDIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = TW'(accr_reg);
                div_req.divisor  = bsts_pkg::MS_PER_S;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Sequence one transaction through the divider passes
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_DECIDE;
            S_DECIDE:  state_next = resync_ok ? S_P0_WAIT : S_PHASE;
            S_P0_WAIT: if (div_rsp.done) state_next = S_CORR;
            S_CORR:    state_next = outside ? S_APPLY : S_GD_WAIT;
            S_GD_WAIT: if (div_rsp.done) state_next = S_APPLY;
            S_APPLY:   state_next = S_PHASE;
            S_PHASE:   state_next = S_PH_WAIT;
            S_PH_WAIT: if (div_rsp.done) state_next = S_GMOD;
            S_GMOD:    state_next = guard_gt_per ? S_GM_WAIT : S_SINCE;
            S_GM_WAIT: if (div_rsp.done) state_next = S_SINCE;
            S_SINCE:   state_next = S_SN_WAIT;
            S_SN_WAIT: if (div_rsp.done) state_next = S_MUL;
            S_MUL:     if (mul_cnt_reg == MCW'(1)) state_next = S_RDIV;
            S_RDIV:    state_next = S_RD_WAIT;
            S_RD_WAIT: if (div_rsp.done) state_next = S_OUT;
            S_OUT:     if (can_load) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Control state: configuration, schedule state, sequencer, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= bsts_pkg::PERIOD_RESET;
            guard_reg      <= bsts_pkg::GUARD_RESET;
            rx_reg         <= bsts_pkg::RX_WINDOW_RESET;
            jitter_reg     <= bsts_pkg::TX_JITTER_RESET;
            gain_reg       <= bsts_pkg::GAIN_RESET;
            ppm_reg        <= bsts_pkg::DRIFT_PPM_RESET;
            init_class_reg <= bsts_pkg::CLASS_RESET;
            epoch_reg      <= '0;
            last_reg       <= '0;
            class_reg      <= bsts_pkg::CLASS_RESET;
            state_reg      <= S_IDLE;
            mul_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    bsts_pkg::REG_PERIOD:     period_reg     <= cfg_data;
                    bsts_pkg::REG_GUARD:      guard_reg      <= cfg_data[9:0];
                    bsts_pkg::REG_RX_WINDOW:  rx_reg         <= cfg_data[9:0];
                    bsts_pkg::REG_TX_JITTER:  jitter_reg     <= cfg_data[9:0];
                    bsts_pkg::REG_GAIN:       gain_reg       <= cfg_data[6:0];
                    bsts_pkg::REG_DRIFT_PPM:  ppm_reg        <= cfg_data[9:0];
                    bsts_pkg::REG_INIT_CLASS: init_class_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            state_reg <= state_next;

            // Anchor the epoch
            if (state_reg == S_DECIDE && req_reg == bsts_pkg::REQ_ANCHOR)
            begin
                epoch_reg <= t_reg;
                last_reg  <= t_reg;
                class_reg <= init_class_reg;
            end

            // Shift the epoch by the correction and, from a better peer, take its class plus one
            if (state_reg == S_APPLY)
            begin
                epoch_reg <= epoch_reg + {{(TW-18){applied_reg[17]}}, applied_reg};
                last_reg  <= t_reg;
                if (peer_reg < class_reg)
                    class_reg <= peer_reg + 8'd1;
            end

            // Count multiplier steps
            if (state_reg == S_SN_WAIT && div_rsp.done)
                mul_cnt_reg <= MCW'(bsts_pkg::PPM_W);
            else if (state_reg == S_MUL)
                mul_cnt_reg <= mul_cnt_reg - MCW'(1);

            // Hold the result until the receiver takes it
            if (state_reg == S_OUT && can_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg     <= req_type;
            t_reg       <= time_ms;
            peer_reg    <= peer_class;
            taken_reg   <= 1'b0;
            applied_reg <= '0;
        end

        if (state_reg == S_P0_WAIT && div_rsp.done)
            off_reg <= off_bias;

        if (state_reg == S_CORR && outside)
            applied_reg <= off_reg;

        if (state_reg == S_GD_WAIT && div_rsp.done)
            applied_reg <= $signed(applied_div);

        if (state_reg == S_APPLY)
            taken_reg <= 1'b1;

        if (state_reg == S_PH_WAIT && div_rsp.done)
            p_reg <= div_rsp.rem;

        // Guard modulo the period, only needed when the guard is wider
        if (state_reg == S_GMOD && !guard_gt_per)
            g_reg <= guard_reg;
        if (state_reg == S_GM_WAIT && div_rsp.done)
            g_reg <= div_rsp.rem[9:0];

        // Load the drift multiplier with whole seconds and leftover milliseconds
        if (state_reg == S_SN_WAIT && div_rsp.done)
        begin
            mq_reg   <= div_rsp.quot[31:0];
            mr_reg   <= 20'(div_rsp.rem);
            mp_reg   <= ppm_reg;
            accq_reg <= '0;
            accr_reg <= '0;
        end

        // Shift-add one ppm bit per cycle
        if (state_reg == S_MUL)
        begin
            if (mp_reg[0])
            begin
                accq_reg <= accq_reg + mq_reg;
                accr_reg <= accr_reg + mr_reg;
            end
            mq_reg <= {mq_reg[30:0], 1'b0};
            mr_reg <= {mr_reg[18:0], 1'b0};
            mp_reg <= {1'b0, mp_reg[9:1]};
        end

        if (state_reg == S_RD_WAIT && div_rsp.done)
            drift_reg <= accq_reg + div_rsp.quot[31:0];

        // Load the result register
        if (state_reg == S_OUT && can_load)
        begin
            open_reg        <= open_c;
            until_next_reg  <= until_next_c;
            until_tx_reg    <= until_tx_c;
            drift_out_reg   <= drift_reg;
            taken_out_reg   <= taken_reg;
            applied_out_reg <= applied_reg[16:0];
            class_out_reg   <= class_reg;
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign slot_open       = open_reg;
    assign until_next_slot = until_next_reg;
    assign until_tx        = until_tx_reg;
    assign drift_us        = drift_out_reg;
    assign resync_taken    = taken_out_reg;
    assign applied_offset  = applied_out_reg;
    assign own_class       = class_out_reg;

    // An accepted transaction always starts in the decision step
    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECIDE))
        else $error("accepted transaction did not enter decision step");

    // Divider completions only arrive while the sequencer waits for one
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_P0_WAIT || state_reg == S_GD_WAIT ||
                          state_reg == S_PH_WAIT || state_reg == S_GM_WAIT ||
                          state_reg == S_SN_WAIT || state_reg == S_RD_WAIT))
        else $error("divider finished outside a wait state");

    // No correction is reported unless a resync was taken
    a_offset_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !resync_taken) |-> (applied_offset == 17'sd0))
        else $error("nonzero offset without resync");

    // A nonzero wait means the window is closed
    a_wait_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && until_next_slot != 16'd0) |-> !slot_open)
        else $error("window open with nonzero wait");

endmodule

FILE: rtl/core/bsts_div.sv
// Bit-serial restoring divider: one quotient bit per cycle over the full time width.
module bsts_div (
    input  logic                clk,
    input  logic                rst_n,
    input  bsts_pkg::div_req_t  req,
    output bsts_pkg::div_rsp_t  rsp
);

    localparam int TW = bsts_pkg::TIME_WIDTH;
    localparam int DW = bsts_pkg::DVS_W;
    localparam int CW = bsts_pkg::CNT_W;

    logic [TW-1:0] work_reg;
    logic [TW-1:0] work_next;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    // Shift in the next dividend bit and try one subtraction
    always_comb
    begin
        shifted = {rem_reg, work_reg[TW-1]};
        diff    = shifted - {1'b0, dvs_reg};
        if (shifted >= {1'b0, dvs_reg})
        begin
            rem_next  = diff[DW-1:0];
            work_next = {work_reg[TW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = shifted[DW-1:0];
            work_next = {work_reg[TW-2:0], 1'b0};
        end
    end

    // Count iterations and flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= CW'(TW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CW'(1);
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Load operands, then advance one bit per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            work_reg <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = work_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: verif/beat_slot_timing_sync_tb.sv
// Self-checking testbench for the slot timing block: directed request table, then random streams.
module beat_slot_timing_sync_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_WIDTH = bsts_pkg::TIME_WIDTH;
    localparam int CFG_IDX_W  = bsts_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = bsts_pkg::CFG_DATA_W;

    localparam int NUM_REGS         = 7;
    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 105;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES    = 400;
    localparam int IDLE_PERCENT     = 9;

    // The spare request code behaves as a query
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic               is_open;
        logic [15:0]        wait_ms;
        logic [16:0]        tx_ms;
        logic [31:0]        drift;
        logic               taken;
        logic signed [16:0] offset;
        logic [7:0]         cls;
    } slot_report_t;

    typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [1:0]            req;
        logic [TIME_WIDTH-1:0] stamp;
        logic [7:0]            peer;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        bit                    known;
        slot_report_t          report;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              req_type;
    logic [TIME_WIDTH-1:0]   time_ms;
    logic [7:0]              peer_class;
    logic                    out_valid;
    logic                    out_ready;
    logic                    slot_open;
    logic [15:0]             until_next_slot;
    logic [16:0]             until_tx;
    logic [31:0]             drift_us;
    logic                    resync_taken;
    logic signed [16:0]      applied_offset;
    logic [7:0]              own_class;

    // Mirror of the register file
    logic [15:0] m_period     = bsts_pkg::PERIOD_RESET;
    logic [9:0]  m_guard      = bsts_pkg::GUARD_RESET;
    logic [9:0]  m_rx         = bsts_pkg::RX_WINDOW_RESET;
    logic [9:0]  m_jitter     = bsts_pkg::TX_JITTER_RESET;
    logic [6:0]  m_gain       = bsts_pkg::GAIN_RESET;
    logic [9:0]  m_ppm        = bsts_pkg::DRIFT_PPM_RESET;
    logic [7:0]  m_init_class = bsts_pkg::CLASS_RESET;

    // Mirror of the schedule state
    logic [TIME_WIDTH-1:0] epoch     = '0;
    logic [TIME_WIDTH-1:0] last_sync = '0;
    logic [7:0]            own_cls   = bsts_pkg::CLASS_RESET;

    slot_report_t pending_reports[$];
    stim_row_t    directed_rows[$];

    int errors     = 0;
    int n_anchor   = 0;
    int n_query    = 0;
    int n_taken    = 0;
    int n_ignored  = 0;
    int n_settings = 0;
    bit calm       = 1'b0;
    bit stall_ask  = 1'b0;
    bit offering   = 1'b0;

    beat_slot_timing_sync DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Time since the epoch, wrapped at the time width, reduced by the period
    function automatic int unsigned phase_of(logic [TIME_WIDTH-1:0] stamp, int unsigned per);
        logic [TIME_WIDTH-1:0] since;
        since = stamp - epoch;
        return int'(64'(since) % 64'(per));
    endfunction

    // Apply one request to the mirrored schedule and return the report it yields
    function automatic slot_report_t advance_schedule(logic [1:0] req,
                                                      logic [TIME_WIDTH-1:0] stamp,
                                                      logic [7:0] peer);
        slot_report_t          r;
        int unsigned           per, gd, g_mod, target, p, tx;
        int                    off;
        logic [TIME_WIDTH-1:0] since;
        logic [63:0]           scaled;
        per = (m_period == '0) ? bsts_pkg::PERIOD_DEFAULT : m_period;
        gd  = m_guard;
        r   = '0;
        if (req == bsts_pkg::REQ_ANCHOR)
        begin
            epoch     = stamp;
            last_sync = stamp;
            own_cls   = m_init_class;
            n_anchor++;
        end
        else if (req == bsts_pkg::REQ_RESYNC && peer <= own_cls)
        begin
            // fold the phase into a signed error around the boundary
            off = int'(phase_of(stamp, per));
            if (off > int'(per / 2))
                off -= int'(per);
            // strip the sender's mean jitter, damp errors inside the guard
            off -= int'(m_jitter) / 2;
            if (off <= int'(gd) && off >= -int'(gd))
                off = off / int'((m_gain == '0) ? bsts_pkg::GAIN_DEFAULT : m_gain);
            epoch     = epoch + {{(TIME_WIDTH-32){off[31]}}, off};
            last_sync = stamp;
            if (peer < own_cls)
                own_cls = peer + 8'd1;
            r.taken  = 1'b1;
            r.offset = off[16:0];
            n_taken++;
        end
        else if (req == bsts_pkg::REQ_RESYNC)
            n_ignored++;
        else
            n_query++;

        // window timing from the updated epoch
        p         = phase_of(stamp, per);
        r.is_open = (p < m_rx + gd) || (gd <= per && p >= per - gd);
        r.wait_ms = r.is_open ? 16'd0 : 16'(per - gd - p);
        g_mod     = (gd > per) ? gd % per : gd;
        target    = per - g_mod;
        tx        = (p <= target) ? target - p : per - p + target;
        r.tx_ms   = 17'(tx);

        // drift since the last resync, exact product then low 32 bits
        since   = stamp - last_sync;
        scaled  = (64'(since) / 64'(bsts_pkg::MS_PER_S)) * m_ppm
                + ((64'(since) % 64'(bsts_pkg::MS_PER_S)) * m_ppm) / 64'(bsts_pkg::MS_PER_S);
        r.drift = scaled[31:0];
        r.cls   = own_cls;
        return r;
    endfunction

    function automatic stim_row_t item_row(logic [1:0] req, logic [TIME_WIDTH-1:0] stamp,
                                           logic [7:0] peer);
        stim_row_t row;
        row.kind   = ROW_ITEM;
        row.req    = req;
        row.stamp  = stamp;
        row.peer   = peer;
        row.idx    = '0;
        row.val    = '0;
        row.known  = 1'b0;
        row.report = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(logic [1:0] req, logic [TIME_WIDTH-1:0] stamp,
                                            logic [7:0] peer, bit is_open, int wait_ms,
                                            int tx_ms, int drift, bit taken, int offset,
                                            int cls);
        stim_row_t row;
        row        = item_row(req, stamp, peer);
        row.known  = 1'b1;
        row.report = '{is_open, 16'(wait_ms), 17'(tx_ms), 32'(drift), taken,
                       17'(offset), 8'(cls)};
        return row;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int val);
        stim_row_t row;
        row.kind   = ROW_REG;
        row.req    = bsts_pkg::REQ_QUERY;
        row.stamp  = '0;
        row.peer   = '0;
        row.idx    = idx;
        row.val    = CFG_DATA_W'(val);
        row.known  = 1'b0;
        row.report = '0;
        return row;
    endfunction

    // Offer one transaction, then record its expected report once accepted
    task automatic push_request(logic [1:0] req, logic [TIME_WIDTH-1:0] stamp,
                                logic [7:0] peer, bit known, slot_report_t report);
        slot_report_t predicted;
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            if (offering)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
            end
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        offering   = 1'b1;
        req_type   <= req;
        time_ms    <= stamp;
        peer_class <= peer;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = advance_schedule(req, stamp, peer);
        pending_reports.push_back(known ? report : predicted);
    endtask

    // Stop offering and wait until every report has come back
    task automatic drain_requests();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            @(posedge clk);
        end
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            bsts_pkg::REG_PERIOD:     m_period     = val;
            bsts_pkg::REG_GUARD:      m_guard      = val[9:0];
            bsts_pkg::REG_RX_WINDOW:  m_rx         = val[9:0];
            bsts_pkg::REG_TX_JITTER:  m_jitter     = val[9:0];
            bsts_pkg::REG_GAIN:       m_gain       = val[6:0];
            bsts_pkg::REG_DRIFT_PPM:  m_ppm        = val[9:0];
            bsts_pkg::REG_INIT_CLASS: m_init_class = val[7:0];
            default: ;
        endcase
        n_settings++;
    endtask

    // Program one register setting, then stream random requests against it
    task automatic run_random_phase(int phase);
        int unsigned           setting [NUM_REGS];
        logic [1:0]            req;
        logic [TIME_WIDTH-1:0] stamp;
        logic [7:0]            peer;
        int unsigned           per, reach, pick;
        int                    dev;
        slot_report_t          none;
        none = '0;
        drain_requests();
        calm = (phase == 0);
        case (phase)
            0:
            begin
                setting[bsts_pkg::REG_PERIOD]     = int'(bsts_pkg::PERIOD_RESET);
                setting[bsts_pkg::REG_GUARD]      = int'(bsts_pkg::GUARD_RESET);
                setting[bsts_pkg::REG_RX_WINDOW]  = int'(bsts_pkg::RX_WINDOW_RESET);
                setting[bsts_pkg::REG_TX_JITTER]  = int'(bsts_pkg::TX_JITTER_RESET);
                setting[bsts_pkg::REG_GAIN]       = int'(bsts_pkg::GAIN_RESET);
                setting[bsts_pkg::REG_DRIFT_PPM]  = int'(bsts_pkg::DRIFT_PPM_RESET);
                setting[bsts_pkg::REG_INIT_CLASS] = int'(bsts_pkg::CLASS_RESET);
            end
            1:
            begin
                setting[bsts_pkg::REG_PERIOD]     = $urandom_range(5000, 100);
                setting[bsts_pkg::REG_GUARD]      = $urandom_range(60);
                setting[bsts_pkg::REG_RX_WINDOW]  = $urandom_range(100);
                setting[bsts_pkg::REG_TX_JITTER]  = $urandom_range(40);
                setting[bsts_pkg::REG_GAIN]       = $urandom_range(16, 1);
                setting[bsts_pkg::REG_DRIFT_PPM]  = $urandom_range(1000);
                setting[bsts_pkg::REG_INIT_CLASS] = $urandom_range(255);
            end
            2:
            begin
                // short periods, guard often beyond the period
                setting[bsts_pkg::REG_PERIOD]     = $urandom_range(40, 1);
                setting[bsts_pkg::REG_GUARD]      = $urandom_range(60);
                setting[bsts_pkg::REG_RX_WINDOW]  = $urandom_range(50);
                setting[bsts_pkg::REG_TX_JITTER]  = $urandom_range(20);
                setting[bsts_pkg::REG_GAIN]       = $urandom_range(8, 1);
                setting[bsts_pkg::REG_DRIFT_PPM]  = $urandom_range(1000);
                setting[bsts_pkg::REG_INIT_CLASS] = $urandom_range(255);
            end
            3:
            begin
                setting[bsts_pkg::REG_PERIOD]     = 1;
                setting[bsts_pkg::REG_GUARD]      = 0;
                setting[bsts_pkg::REG_RX_WINDOW]  = 0;
                setting[bsts_pkg::REG_TX_JITTER]  = 0;
                setting[bsts_pkg::REG_GAIN]       = 1;
                setting[bsts_pkg::REG_DRIFT_PPM]  = 0;
                setting[bsts_pkg::REG_INIT_CLASS] = 0;
            end
            4:
            begin
                setting[bsts_pkg::REG_PERIOD]     = 65535;
                setting[bsts_pkg::REG_GUARD]      = 1000;
                setting[bsts_pkg::REG_RX_WINDOW]  = 1000;
                setting[bsts_pkg::REG_TX_JITTER]  = 1000;
                setting[bsts_pkg::REG_GAIN]       = 64;
                setting[bsts_pkg::REG_DRIFT_PPM]  = 1000;
                setting[bsts_pkg::REG_INIT_CLASS] = 255;
            end
            default:
            begin
                // zero period and zero gain fall back to their defaults
                setting[bsts_pkg::REG_PERIOD]     = 0;
                setting[bsts_pkg::REG_GUARD]      = $urandom_range(1000);
                setting[bsts_pkg::REG_RX_WINDOW]  = $urandom_range(1000);
                setting[bsts_pkg::REG_TX_JITTER]  = $urandom_range(1000);
                setting[bsts_pkg::REG_GAIN]       = 0;
                setting[bsts_pkg::REG_DRIFT_PPM]  = $urandom_range(1000);
                setting[bsts_pkg::REG_INIT_CLASS] = $urandom_range(255);
            end
        endcase
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'(setting[i]));

        for (int k = 0; k < ITEMS_PER_PHASE; k++)
        begin
            // pressure: long receiver hold-off, later a full drain mid-stream
            if (phase == 1 && k == 10)
                stall_ask = 1'b1;
            if (phase == 1 && k == 60)
                drain_requests();

            per   = (m_period == '0) ? bsts_pkg::PERIOD_DEFAULT : m_period;
            reach = m_guard + m_jitter / 2 + 3;
            pick  = $urandom_range(99);
            peer  = own_cls;
            // land near a slot boundary up to 3000 periods past the epoch
            dev   = int'($urandom_range(2 * reach)) - int'(reach);
            stamp = epoch + 48'(per) * 48'($urandom_range(3000))
                  + {{(TIME_WIDTH-32){dev[31]}}, dev};
            if (pick < 8)
            begin
                req = bsts_pkg::REQ_ANCHOR;
                case ($urandom_range(3))
                    0: stamp = {16'($urandom), 32'($urandom)};
                    1: stamp = TIME_MAX - 48'($urandom_range(5000));
                    default: ;
                endcase
            end
            else if (pick < 38)
            begin
                req = bsts_pkg::REQ_QUERY;
                if ($urandom_range(3) == 0)
                    stamp = {16'($urandom), 32'($urandom)};
                else
                    stamp = stamp + 48'($urandom_range(per - 1));
            end
            else if (pick < 88)
            begin
                req = bsts_pkg::REQ_RESYNC;
                case ($urandom_range(3))
                    2: peer = 8'($urandom_range(own_cls));
                    3: peer = 8'($urandom_range(255));
                    default: ;
                endcase
            end
            else if (pick < 93)
                req = REQ_SPARE;
            else
            begin
                req   = 2'($urandom_range(3));
                stamp = {16'($urandom), 32'($urandom)};
                peer  = 8'($urandom_range(255));
            end
            push_request(req, stamp, peer, 1'b0, none);
        end
    endtask

    task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Receiver: random back-pressure, one long hold on request, check each report
    initial
    begin : result_side
        int           hold_left;
        slot_report_t want;
        hold_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: report arrived with no request outstanding", $time);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("slot_open", want.is_open, slot_open);
                    check_field("until_next_slot", want.wait_ms, until_next_slot);
                    check_field("until_tx", want.tx_ms, until_tx);
                    check_field("drift_us", want.drift, drift_us);
                    check_field("resync_taken", want.taken, resync_taken);
                    check_field("applied_offset", want.offset, applied_offset);
                    check_field("own_class", want.cls, own_class);
                end
            end
            if (stall_ask)
            begin
                hold_left = LONG_HOLD_CYCLES;
                stall_ask = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Sender: reset, directed table, then random phases
    initial
    begin : request_side
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = bsts_pkg::REQ_QUERY;
        time_ms    = '0;
        peer_class = '0;

        // after reset, then default settings walked through each resync outcome
        directed_rows.push_back(known_row(bsts_pkg::REQ_QUERY, 0, 0,
                                          1, 0, 990, 0, 0, 0, 255));
        directed_rows.push_back(known_row(bsts_pkg::REQ_ANCHOR, 5000, 0,
                                          1, 0, 990, 0, 0, 0, 255));
        directed_rows.push_back(item_row(bsts_pkg::REQ_QUERY, 5500, 0));
        // equal class, damped small offset rounds to nothing
        directed_rows.push_back(item_row(bsts_pkg::REQ_RESYNC, 6003, 255));
        // better peer, offset beyond the guard applied in full
        directed_rows.push_back(item_row(bsts_pkg::REQ_RESYNC, 7100, 7));
        // worse peer is ignored
        directed_rows.push_back(item_row(bsts_pkg::REQ_RESYNC, 7600, 9));
        // late phase folds to a negative offset
        directed_rows.push_back(item_row(bsts_pkg::REQ_RESYNC, 7900, 3));
        // division truncates toward zero on both signs
        directed_rows.push_back(item_row(bsts_pkg::REQ_RESYNC, 8907, 4));
        directed_rows.push_back(item_row(bsts_pkg::REQ_RESYNC, 9894, 4));
        directed_rows.push_back(item_row(bsts_pkg::REQ_QUERY, TIME_MAX, 0));
        directed_rows.push_back(item_row(REQ_SPARE, 10500, 0));
        // anchor just below the wrap, then query past it
        directed_rows.push_back(known_row(bsts_pkg::REQ_ANCHOR, TIME_MAX - 255, 0,
                                          1, 0, 990, 0, 0, 0, 255));
        directed_rows.push_back(item_row(bsts_pkg::REQ_QUERY, 48'h100, 0));
        // zero period and zero gain
        directed_rows.push_back(reg_row(bsts_pkg::REG_PERIOD, 0));
        directed_rows.push_back(item_row(bsts_pkg::REQ_QUERY, 12345, 0));
        directed_rows.push_back(reg_row(bsts_pkg::REG_GAIN, 0));
        directed_rows.push_back(item_row(bsts_pkg::REQ_RESYNC, 13007, 0));
        // guard wider than the period
        directed_rows.push_back(reg_row(bsts_pkg::REG_PERIOD, 7));
        directed_rows.push_back(reg_row(bsts_pkg::REG_GUARD, 9));
        directed_rows.push_back(item_row(bsts_pkg::REQ_QUERY, 1000, 0));
        directed_rows.push_back(item_row(bsts_pkg::REQ_RESYNC, 1003, 0));
        // maximum period, large values in the other registers, lowest initial class
        directed_rows.push_back(reg_row(bsts_pkg::REG_PERIOD, 65535));
        directed_rows.push_back(reg_row(bsts_pkg::REG_GUARD, 1000));
        directed_rows.push_back(reg_row(bsts_pkg::REG_RX_WINDOW, 1000));
        directed_rows.push_back(reg_row(bsts_pkg::REG_TX_JITTER, 1000));
        directed_rows.push_back(reg_row(bsts_pkg::REG_GAIN, 64));
        directed_rows.push_back(reg_row(bsts_pkg::REG_DRIFT_PPM, 1000));
        directed_rows.push_back(reg_row(bsts_pkg::REG_INIT_CLASS, 0));
        directed_rows.push_back(known_row(bsts_pkg::REQ_ANCHOR, 0, 255,
                                          1, 0, 64535, 0, 0, 0, 0));
        directed_rows.push_back(item_row(bsts_pkg::REQ_QUERY, TIME_MAX, 0));
        directed_rows.push_back(item_row(bsts_pkg::REQ_RESYNC, 40000, 0));
        directed_rows.push_back(item_row(bsts_pkg::REQ_RESYNC, 40100, 255));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                drain_requests();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end
            else
                push_request(directed_rows[i].req, directed_rows[i].stamp,
                             directed_rows[i].peer, directed_rows[i].known,
                             directed_rows[i].report);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
            run_random_phase(ph);

        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d anchors, %0d queries, %0d resyncs taken, %0d ignored.",
                 n_anchor, n_query, n_taken, n_ignored);
        $display("Used %0d register writes incl. zero, minimum and maximum; %0d mismatches.",
                 n_settings, errors);
        if (errors == 0)
            $display("** beat_slot_timing_sync: PASSED **");
        else
            $display("** beat_slot_timing_sync: FAILED **");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin : watchdog
        #12_000_000;
        $display("Timeout with %0d reports outstanding", pending_reports.size());
        $display("** beat_slot_timing_sync: FAILED **");
        $finish;
    end

endmodule
